FILE: rtl/can_frame_replay_detector_macros.svh
// Assertion macros for the CAN frame replay detector.
// Used by the top level only; needs no other file.
`ifndef CAN_FRAME_REPLAY_DETECTOR_MACROS_SVH
`define CAN_FRAME_REPLAY_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define CFRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfrd: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define CFRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfrd: next-cycle check failed");
`else
`define CFRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/cfrd_pkg.sv
// Shared types and constants of the CAN frame replay detector.
// No dependencies; imported by the controller, the datapath and the top level.
package cfrd_pkg;

  // Field widths
  localparam int ID_W     = 29;
  localparam int PAYLD_W  = 64;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Defaults
  localparam int             CFRD_TABLE_DEPTH = 32;
  localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd60;
  localparam logic [CFG_W-1:0] THRESH_RESET   = 16'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PAYLD_W-1:0] payload;
    logic [TIME_W-1:0]  start;
    logic [CNT_W-1:0]   repeats;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch the frame, rewind the scan
    logic issue;     // read the entry at the scan index
    logic hit_upd;   // update the matched entry
    logic miss_upd;  // append the frame or flag table full
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic match;     // read entry equals the frame
    logic q_vld;     // a read is in flight
    logic scan_end;  // scan index reached the fill level
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

FILE: rtl/can_frame_replay_detector.sv
// Top level of the CAN frame replay detector: controller plus datapath.
// Uses cfrd_pkg and can_frame_replay_detector_macros.svh.
//
// Each accepted frame is looked up by identifier and payload in a table of
// TABLE_DEPTH entries, filled in arrival order and searched from entry 0,
// one entry per cycle through the registered read port of the entry
// memory. The scan stops at a matching entry or at the fill level; then the
// matched entry is updated or the frame is appended (or the table flagged
// full), and the result is moved into the output register. One frame is
// in work at a time; the result sits in that register, so the next frame
// is taken as soon as it is loaded, even if the result is still stalled.
// The table needs no clearing after reset. Configuration (index 0: window
// in seconds, index 1: repeat threshold) is always ready and is to be
// written only while no frame is in work.
`include "can_frame_replay_detector_macros.svh"

module can_frame_replay_detector #(
  parameter int TABLE_DEPTH = cfrd_pkg::CFRD_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cfrd_pkg::ID_W-1:0]       in_frame_id,
  input  logic [cfrd_pkg::PAYLD_W-1:0]    in_frame_payload,
  input  logic [cfrd_pkg::TIME_W-1:0]     in_now_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_replay_found,
  output logic                            out_table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfrd_pkg::CFG_W-1:0]      cfg_data
);
  import cfrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cfrd_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfrd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_frame_id      (in_frame_id),
    .in_frame_payload (in_frame_payload),
    .in_now_seconds   (in_now_seconds),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_replay_found (out_replay_found),
    .out_table_full   (out_table_full)
  );

  // A read is only issued for a filled entry
  `CFRD_ASSERT_IMP(a_issue_in_fill, clk, rst_n, cmd.issue, !sts.scan_end)
  // An accepted frame keeps the input side busy in the next cycle
  `CFRD_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // A result never flags both a replay and a full table
  `CFRD_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid,
                   !(out_replay_found && out_table_full))

endmodule

FILE: rtl/cfrd_datapath.sv
// Datapath of the replay detector: entry memory, scan index, fill level,
// configuration registers, entry update and output register. Uses cfrd_pkg.
module cfrd_datapath #(
  parameter int TABLE_DEPTH = cfrd_pkg::CFRD_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfrd_pkg::cmd_t                  cmd,
  output cfrd_pkg::sts_t                  sts,
  input  logic [cfrd_pkg::ID_W-1:0]       in_frame_id,
  input  logic [cfrd_pkg::PAYLD_W-1:0]    in_frame_payload,
  input  logic [cfrd_pkg::TIME_W-1:0]     in_now_seconds,
  input  logic                            cfg_valid,
  input  logic [cfrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfrd_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_replay_found,
  output logic                            out_table_full
);
  import cfrd_pkg::*;

  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);

  entry_t entry_mem_r [TABLE_DEPTH];

  logic [ID_W-1:0]    key_id_r;
  logic [PAYLD_W-1:0] key_pl_r;
  logic [TIME_W-1:0]  key_now_r;
  logic [FW-1:0]      idx_r, idx_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  entry_t             rd_q_r;
  logic [AW-1:0]      q_idx_r;
  logic               q_vld_r;
  logic [CFG_W-1:0]   window_r, window_nxt;
  logic [CFG_W-1:0]   thresh_r, thresh_nxt;
  logic               res_replay_r, res_full_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_replay_r, out_full_r;

  logic               tbl_full;
  logic [CNT_W-1:0]   cnt_inc;
  logic [TIME_W-1:0]  elapsed;
  logic               in_win;
  logic               thr_hit;
  logic               hit_replay;
  entry_t             upd_entry;
  entry_t             new_entry;

  // Status to the controller
  assign tbl_full     = (fill_r >= DEPTH_F);
  assign sts.match    = q_vld_r && (rd_q_r.id == key_id_r) && (rd_q_r.payload == key_pl_r);
  assign sts.q_vld    = q_vld_r;
  assign sts.scan_end = (idx_r >= fill_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Hit update: saturate the count, check window and threshold
  assign cnt_inc  = (rd_q_r.repeats != {CNT_W{1'b1}}) ? rd_q_r.repeats + CNT_W'(1)
                                                       : rd_q_r.repeats;
  assign elapsed  = key_now_r - rd_q_r.start;
  assign in_win   = $signed(elapsed) <= $signed({{(TIME_W-CFG_W){1'b0}}, window_r});
  assign thr_hit  = (cnt_inc >= thresh_r);
  assign hit_replay = in_win && thr_hit;

  always_comb begin
    upd_entry = rd_q_r;
    if (in_win && !thr_hit) begin
      upd_entry.repeats = cnt_inc;
    end else begin
      upd_entry.repeats = CNT_W'(1);
      upd_entry.start   = key_now_r;
    end
  end

  assign new_entry = '{id: key_id_r, payload: key_pl_r, start: key_now_r,
                       repeats: CNT_W'(1)};

  // Latch the frame on acceptance
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_id_r  <= in_frame_id;
      key_pl_r  <= in_frame_payload;
      key_now_r <= in_now_seconds;
    end
  end

  // Advance the scan index and the fill level
  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.issue) begin
      idx_nxt = idx_r + FW'(1);
    end
    if (cmd.miss_upd && !tbl_full) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  // Configuration writes
  always_comb begin
    window_nxt = window_r;
    thresh_nxt = thresh_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW: window_nxt = cfg_data;
        REG_THRESH: thresh_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the output until it is taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      fill_r      <= '0;
      q_vld_r     <= 1'b0;
      window_r    <= WINDOW_RESET;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      q_vld_r     <= cmd.issue;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Registered read of the entry memory
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_q_r  <= entry_mem_r[idx_r[AW-1:0]];
      q_idx_r <= idx_r[AW-1:0];
    end
  end

  // Write back a hit or append a new entry
  always_ff @(posedge clk) begin
    if (cmd.hit_upd) begin
      entry_mem_r[q_idx_r] <= upd_entry;
    end else if (cmd.miss_upd && !tbl_full) begin
      entry_mem_r[fill_r[AW-1:0]] <= new_entry;
    end
  end

  // Capture the result flags
  always_ff @(posedge clk) begin
    if (cmd.hit_upd) begin
      res_replay_r <= hit_replay;
      res_full_r   <= 1'b0;
    end else if (cmd.miss_upd) begin
      res_replay_r <= 1'b0;
      res_full_r   <= tbl_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_replay_r <= res_replay_r;
      out_full_r   <= res_full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_replay_found = out_replay_r;
  assign out_table_full   = out_full_r;

endmodule

FILE: rtl/cfrd_controller.sv
// Controller of the replay detector: sequences accept, table scan, update
// and result hand-off. Uses cfrd_pkg types; drives the datapath commands.
module cfrd_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cfrd_pkg::sts_t   sts,
  output cfrd_pkg::cmd_t   cmd
);
  import cfrd_pkg::*;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.match) begin
          state_nxt = ST_HIT;
        end else if (!sts.q_vld && sts.scan_end) begin
          state_nxt = ST_MISS;
        end
      end
      ST_HIT:  state_nxt = ST_DONE;
      ST_MISS: state_nxt = ST_DONE;
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN: cmd.issue    = !sts.match && !sts.scan_end;
      ST_HIT:  cmd.hit_upd  = 1'b1;
      ST_MISS: cmd.miss_upd = 1'b1;
      ST_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
